// ----- src/hpq_pkg.sv -----
// Shared types, widths and codes for the max-heap priority queue.
`default_nettype none

package hpq_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned OCC_W        = 11;

  // Operation codes carried by kind.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // One result, as the sequencer hands it to the top level.
  typedef struct packed {
    logic                     strobe;
    logic signed [DATA_W-1:0] max_value;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;
  } hpq_result_t;

endpackage

`default_nettype wire

// ----- src/hpq_mem.sv -----
// Heap storage: one write port and two registered read ports.
`default_nettype none

module hpq_mem
  import hpq_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned DW    = DATA_W,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic signed [DW-1:0] wdata_i,
  input  wire logic [AW-1:0]        raddr_a_i,
  input  wire logic [AW-1:0]        raddr_b_i,
  output logic signed [DW-1:0]      rdata_a_o,
  output logic signed [DW-1:0]      rdata_b_o
);

  logic signed [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ----- src/hpq_ctrl.sv -----
// Sequencer that runs the sift-up and sift-down walks over the heap storage.
`default_nettype none

module hpq_ctrl
  import hpq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned PW      = $clog2(CAPACITY + 1),
  localparam int unsigned AW      = $clog2(CAPACITY)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  input  wire logic                     kind_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          busy,
  output hpq_result_t                   result_o,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic signed [DATA_W-1:0]      mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_a_o,
  output logic [AW-1:0]                 mem_raddr_b_o,
  input  wire logic signed [DATA_W-1:0] mem_rdata_a_i,
  input  wire logic signed [DATA_W-1:0] mem_rdata_b_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_RM_LD  = 3'd3;
  localparam logic [2:0] S_DN_RD  = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [PW-1:0]            cnt_q, cnt_d;
  logic [PW-1:0]            pos_q, pos_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic signed [DATA_W-1:0] top_q, top_d;
  hpq_result_t              res_q, res_d;

  logic [PW:0]              child_l;
  logic [PW:0]              cnt_ext;
  logic [PW:0]              pick_pos;
  logic signed [DATA_W-1:0] pick_val;

  assign child_l = {pos_q, 1'b0};
  assign cnt_ext = {1'b0, cnt_q};

  // The right child wins only when it exists and is strictly greater.
  always_comb begin
    pick_pos = child_l;
    pick_val = mem_rdata_a_i;
    if ((child_l < cnt_ext) && (mem_rdata_b_i > mem_rdata_a_i)) begin
      pick_pos = child_l + (PW + 1)'(1);
      pick_val = mem_rdata_b_i;
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    pos_d         = pos_q;
    val_d         = val_q;
    top_d         = top_q;
    res_d         = '0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = AW'(pos_q - PW'(1));
    mem_wdata_o   = val_q;
    mem_raddr_a_o = '0;
    mem_raddr_b_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (kind_i == KIND_INSERT) begin
            if (cnt_q == PW'(CAPACITY)) begin
              res_d = '{strobe: 1'b1, max_value: '0, status: ST_FULL,
                        occupancy: OCC_W'(cnt_q)};
            end else begin
              cnt_d   = cnt_q + PW'(1);
              pos_d   = cnt_q + PW'(1);
              val_d   = value_i;
              state_d = S_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              res_d = '{strobe: 1'b1, max_value: '0, status: ST_EMPTY,
                        occupancy: OCC_W'(cnt_q)};
            end else begin
              // Fetch the root and the last entry together.
              mem_raddr_a_o = '0;
              mem_raddr_b_o = AW'(cnt_q - PW'(1));
              cnt_d         = cnt_q - PW'(1);
              pos_d         = PW'(1);
              state_d       = S_RM_LD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_q == PW'(1)) begin
          mem_we_o = 1'b1;
          res_d    = '{strobe: 1'b1, max_value: '0, status: ST_OK,
                       occupancy: OCC_W'(cnt_q)};
          state_d  = S_IDLE;
        end else begin
          mem_raddr_a_o = AW'((pos_q >> 1) - PW'(1));
          state_d       = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        if (mem_rdata_a_i < val_q) begin
          // Parent moves down one level and the hole climbs.
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_a_i;
          pos_d       = pos_q >> 1;
          state_d     = S_UP_RD;
        end else begin
          mem_we_o = 1'b1;
          res_d    = '{strobe: 1'b1, max_value: '0, status: ST_OK,
                       occupancy: OCC_W'(cnt_q)};
          state_d  = S_IDLE;
        end
      end

      S_RM_LD: begin
        top_d   = mem_rdata_a_i;
        val_d   = mem_rdata_b_i;
        state_d = S_DN_RD;
      end

      S_DN_RD: begin
        if (child_l <= cnt_ext) begin
          mem_raddr_a_o = AW'(child_l - (PW + 1)'(1));
          mem_raddr_b_o = AW'(child_l);
          state_d       = S_DN_CMP;
        end else begin
          mem_we_o = 1'b1;
          res_d    = '{strobe: 1'b1, max_value: top_q, status: ST_OK,
                       occupancy: OCC_W'(cnt_q)};
          state_d  = S_IDLE;
        end
      end

      S_DN_CMP: begin
        if (pick_val <= val_q) begin
          mem_we_o = 1'b1;
          res_d    = '{strobe: 1'b1, max_value: top_q, status: ST_OK,
                       occupancy: OCC_W'(cnt_q)};
          state_d  = S_IDLE;
        end else begin
          mem_we_o    = 1'b1;
          mem_wdata_o = pick_val;
          pos_d       = PW'(pick_pos);
          state_d     = S_DN_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    top_q <= top_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign result_o = res_q;

endmodule

`default_nettype wire

// ----- src/max_heap_priority_queue.sv -----
// Top level of the binary max-heap priority queue.
//
// The queue holds up to CAPACITY signed 32-bit values in a one-based binary
// max-heap kept in a synchronous memory with two read ports and one write
// port. An item is taken at a rising edge where start is high and busy is
// low; kind_i selects insert or remove-maximum. Every item produces exactly
// one result, presented for a single cycle with strobe high, and the
// receiver cannot hold it off, so it must sample the result in that cycle.
// A refused item (insert into a full heap, remove from an empty heap) is
// answered in the cycle after acceptance and busy never rises. Otherwise
// busy stays high while the walk runs and the result appears in the same
// cycle as busy falls. Each level of the walk costs a memory read and then
// a compare and write-back, and no new item is taken until the walk ends.
// Results carry the maximum removed (zero otherwise), a status code and the
// entry count after the item, reduced to 11 bits. The memory needs no
// clearing after reset: an entry's value is only used once it is written.
`default_nettype none

module max_heap_priority_queue
  import hpq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     kind_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          strobe,
  output logic signed [DATA_W-1:0]      max_value_o,
  output logic [STATUS_W-1:0]           status_o,
  output logic [OCC_W-1:0]              occupancy_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  hpq_result_t              result;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr_a;
  logic [AW-1:0]            mem_raddr_b;
  logic signed [DATA_W-1:0] mem_rdata_a;
  logic signed [DATA_W-1:0] mem_rdata_b;

  // The sequencer owns the entry count and the sift walks.
  hpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .busy          (busy),
    .result_o      (result),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  // Heap slot n lives at memory address n-1.
  hpq_mem #(
    .DEPTH (CAPACITY),
    .DW    (DATA_W)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  assign strobe      = result.strobe;
  assign max_value_o = result.max_value;
  assign status_o    = result.status;
  assign occupancy_o = result.occupancy;

  // A result only appears once the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni) strobe |-> !busy)
    else $error("result presented while the queue is still busy");

  // Every accepted item either starts a walk or is answered at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || strobe))
    else $error("accepted item neither started nor answered");

  // A refused insert is only reported with the heap full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && (status_o == ST_FULL)) |-> (occupancy_o == OCC_W'(CAPACITY)))
    else $error("full status with a heap that is not full");

  // A remove from an empty heap returns zero and an empty count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && (status_o == ST_EMPTY)) |-> ((max_value_o == '0) && (occupancy_o == '0)))
    else $error("empty status with a non-zero value or count");

endmodule

`default_nettype wire

// ----- tb/sv/tb_max_heap_priority_queue.sv -----
// Self-checking testbench for the binary max-heap priority queue.
`default_nettype none

module tb_max_heap_priority_queue;
  import hpq_pkg::*;

  localparam int unsigned HEAP_DEPTH     = CAPACITY_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned REPORT_LIMIT   = 10;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // The fields of one result as the queue reports them.
  typedef struct packed {
    logic signed [DATA_W-1:0] max_value;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;
  } heap_reply_t;

  // One row of the directed stimulus. Where fixed is set the reply is typed
  // in by hand and replaces the predicted one.
  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] value;
    logic                     fixed;
    heap_reply_t              reply;
  } directed_row_t;

  logic                     clk_i   = 1'b0;
  logic                     rst_ni  = 1'b0;
  logic                     start   = 1'b0;
  logic                     kind_i  = KIND_INSERT;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     busy;
  logic                     strobe;
  logic signed [DATA_W-1:0] max_value_o;
  logic [STATUS_W-1:0]      status_o;
  logic [OCC_W-1:0]         occupancy_o;

  max_heap_priority_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .strobe     (strobe),
    .max_value_o(max_value_o),
    .status_o   (status_o),
    .occupancy_o(occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  // Our own copy of the heap, one-based, and the replies still to come.
  logic signed [DATA_W-1:0] model_heap [1:HEAP_DEPTH];
  int unsigned              model_len = 0;
  heap_reply_t              pending_results [$];
  directed_row_t            directed_rows [$];

  int unsigned idle_pct     = 0;
  int unsigned error_count  = 0;
  int unsigned stall_cycles = 0;

  // Applies one item to the shadow heap and returns the reply it must cause.
  // Both sift directions move only on a strict greater-than, so equal values
  // stay put, exactly as the queue is meant to behave.
  function automatic heap_reply_t heap_apply(input logic kind,
                                             input logic signed [DATA_W-1:0] value);
    heap_reply_t              reply;
    int unsigned              pos;
    int unsigned              child;
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] moved;
    reply = '0;
    if (kind == KIND_INSERT) begin
      if (model_len >= HEAP_DEPTH) begin
        reply.status = ST_FULL;
      end else begin
        model_len++;
        pos = model_len;
        while (pos > 1 && model_heap[pos/2] < value) begin
          model_heap[pos] = model_heap[pos/2];
          pos = pos / 2;
        end
        model_heap[pos] = value;
        reply.status = ST_OK;
      end
    end else if (model_len == 0) begin
      reply.status = ST_EMPTY;
    end else begin
      top   = model_heap[1];
      moved = model_heap[model_len];
      model_len--;
      pos = 1;
      while (2 * pos <= model_len) begin
        child = 2 * pos;
        if (child < model_len && model_heap[child+1] > model_heap[child]) child++;
        if (model_heap[child] <= moved) break;
        model_heap[pos] = model_heap[child];
        pos = child;
      end
      model_heap[pos] = moved;
      reply.max_value = top;
      reply.status    = ST_OK;
    end
    reply.occupancy = OCC_W'(model_len);
    return reply;
  endfunction

  // Random values: a quarter are the extremes, a quarter come from a narrow
  // band so that duplicates are common, and the rest are uniform.
  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      1:       return $signed($urandom_range(16)) - 32'sd8;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic note_error(input string what);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // Presents one item, holds it until the queue takes it, then records the
  // reply it must produce. The sender may first sit idle for a few cycles.
  // Start is left high after acceptance so that back-to-back items never see
  // it lowered and raised within the same step.
  task automatic issue_item(input logic kind, input logic signed [DATA_W-1:0] value,
                            input logic fixed, input heap_reply_t fixed_reply);
    heap_reply_t reply;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    kind_i  <= kind;
    value_i <= value;
    do @(posedge clk_i); while (busy);
    reply = heap_apply(kind, value);
    pending_results.push_back(fixed ? fixed_reply : reply);
  endtask

  task automatic random_item(input int unsigned remove_pct);
    issue_item(($urandom_range(99) < remove_pct) ? KIND_REMOVE : KIND_INSERT,
               random_value(), 1'b0, '0);
  endtask

  // Every result is checked against the oldest outstanding reply. The
  // receiver cannot hold results off, so the strobe is sampled every cycle.
  always @(posedge clk_i) begin : result_check
    heap_reply_t want;
    if (rst_ni && strobe) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("result with nothing outstanding: max %0d status %0d occ %0d",
                             max_value_o, status_o, occupancy_o));
      end else begin
        want = pending_results.pop_front();
        if (want.max_value !== max_value_o || want.status !== status_o ||
            want.occupancy !== occupancy_o) begin
          note_error($sformatf("expected max %0d status %0d occ %0d, got max %0d status %0d occ %0d",
                               want.max_value, want.status, want.occupancy,
                               max_value_o, status_o, occupancy_o));
        end
      end
    end
  end

  // The run is abandoned if neither an item nor a result moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    // Directed items: removes on an empty heap, the value extremes, equal
    // values, and a full drain that must come out in descending order.
    directed_rows = '{
      '{KIND_REMOVE, '0,              1'b1, '{'0,              ST_EMPTY, 11'd0}},
      '{KIND_INSERT, VAL_MIN,         1'b1, '{'0,              ST_OK,    11'd1}},
      '{KIND_REMOVE, '0,              1'b1, '{VAL_MIN,         ST_OK,    11'd0}},
      '{KIND_INSERT, VAL_MAX,         1'b1, '{'0,              ST_OK,    11'd1}},
      '{KIND_INSERT, -32'sd1,         1'b1, '{'0,              ST_OK,    11'd2}},
      '{KIND_INSERT, '0,              1'b1, '{'0,              ST_OK,    11'd3}},
      '{KIND_INSERT, VAL_MIN,         1'b1, '{'0,              ST_OK,    11'd4}},
      '{KIND_INSERT, VAL_MAX,         1'b1, '{'0,              ST_OK,    11'd5}},
      '{KIND_INSERT, 32'sd5,          1'b1, '{'0,              ST_OK,    11'd6}},
      '{KIND_INSERT, 32'sd5,          1'b1, '{'0,              ST_OK,    11'd7}},
      '{KIND_INSERT, 32'sd5,          1'b1, '{'0,              ST_OK,    11'd8}},
      '{KIND_REMOVE, '1,              1'b1, '{VAL_MAX,         ST_OK,    11'd7}},
      '{KIND_REMOVE, VAL_MAX,         1'b1, '{VAL_MAX,         ST_OK,    11'd6}},
      '{KIND_REMOVE, '0,              1'b1, '{32'sd5,          ST_OK,    11'd5}},
      '{KIND_REMOVE, '0,              1'b1, '{32'sd5,          ST_OK,    11'd4}},
      '{KIND_INSERT, 32'sh5555_5555,  1'b0, '0},
      '{KIND_INSERT, 32'shAAAA_AAAA,  1'b0, '0},
      '{KIND_REMOVE, '0,              1'b1, '{32'sh5555_5555,  ST_OK,    11'd5}},
      '{KIND_REMOVE, '0,              1'b1, '{32'sd5,          ST_OK,    11'd4}},
      '{KIND_REMOVE, '0,              1'b1, '{'0,              ST_OK,    11'd3}},
      '{KIND_REMOVE, '0,              1'b1, '{-32'sd1,         ST_OK,    11'd2}},
      '{KIND_REMOVE, '0,              1'b1, '{32'shAAAA_AAAA,  ST_OK,    11'd1}},
      '{KIND_REMOVE, '0,              1'b1, '{VAL_MIN,         ST_OK,    11'd0}},
      '{KIND_REMOVE, '0,              1'b1, '{'0,              ST_EMPTY, 11'd0}}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First stretch: the sender idles about a third of the time.
    idle_pct = 32;
    foreach (directed_rows[i])
      issue_item(directed_rows[i].kind, directed_rows[i].value,
                 directed_rows[i].fixed, directed_rows[i].reply);
    // An even mix keeps the heap shallow and often empty.
    repeat (200) random_item(50);

    // Second stretch: mostly idle, filling the heap to capacity and then
    // hovering at the top, where inserts are refused.
    idle_pct = 73;
    while (model_len < HEAP_DEPTH) random_item(5);
    repeat (40) random_item(30);

    // Last stretch: no idling, mostly removes from a deep heap.
    idle_pct = 0;
    repeat (300) random_item(80);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/hpq_pkg.sv
src/hpq_mem.sv
src/hpq_ctrl.sv
src/max_heap_priority_queue.sv
tb/sv/tb_max_heap_priority_queue.sv
